// ===== hdl/sgas_pkg.sv =====
package sgas_pkg;

  localparam int MaxSteps = 16;
  localparam int IdxW = $clog2(MaxSteps);
  localparam int CntW = $clog2(MaxSteps + 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN = 2'd1;
  localparam logic [1:0] PH_LAND = 2'd2;

  localparam logic [7:0] IDX_ABORT = 8'hFE;
  localparam logic [7:0] IDX_IDLE = 8'hFF;

  localparam logic [1:0] KIND_TAKEOFF = 2'd0;
  localparam logic [1:0] KIND_DELAY = 2'd1;
  localparam logic [1:0] KIND_LAND = 2'd2;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_TAKEOFF = 2'd1;
  localparam logic [1:0] ACT_DELAY = 2'd2;
  localparam logic [1:0] ACT_LAND = 2'd3;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;
  localparam logic [2:0] OP_ABORT = 3'd5;

  localparam logic [2:0] REG_CLIMB = 3'd0;
  localparam logic [2:0] REG_TOL = 3'd1;
  localparam logic [2:0] REG_TD_LEVEL = 3'd2;
  localparam logic [2:0] REG_TD_CONFIRM = 3'd3;
  localparam logic [2:0] REG_EXTRA = 3'd4;
  localparam logic [2:0] REG_ABORT_LAND = 3'd5;
  localparam logic [2:0] REG_RANGE_MAX = 3'd6;

  localparam logic [10:0] HEIGHT_MAX_MM = 11'd2000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_FIN,
    ST_LOAD,
    ST_ENTER,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [10:0] height;
    logic [19:0] time_ms;
    logic [19:0] timeout_ms;
  } step_t;

  typedef struct packed {
    logic start;
    logic [47:0] dividend;
    logic [19:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic [47:0] quotient;
  } div_rsp_t;

endpackage

// ===== hdl/sgas_div.sv =====
module sgas_div
  import sgas_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [47:0] quo;
  logic [20:0] rem;
  logic [5:0] cnt;
  logic busy;
  logic [19:0] dvs;
  logic [20:0] trial;

  assign trial = {rem[19:0], quo[47]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        cnt <= 6'd47;
      end else if (busy) begin
        if (cnt == 6'd0) busy <= 1'b0;
        cnt <= cnt - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        quo <= {quo[46:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[46:0], 1'b0};
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.quotient = quo;

endmodule

// ===== hdl/sensor_gated_altitude_step_sequencer_top.sv =====
// Each accepted input word passes through the READ, EXEC, DIV, FIN, LOAD and ENTER
// states before the result word is valid in OUT; a tick that ramps a takeoff or a
// landing also waits in DIV for the shared divider. One word at a time: s_tready is
// low from accept until the result word is taken, also through m_tready stalls.
// Reset (rst, synchronous): registers to their reset values, program empty.
module sensor_gated_altitude_step_sequencer_top
  import sgas_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[2:0], now_ms[34:3], range_mm[50:35], step_kind[52:51],
  // step_height_mm[63:53], step_time_ms[83:64], step_timeout_ms[103:84],
  // planner_stopped[104], zeros above
  input  logic [111:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // rejected[0], phase[2:1], step_index[10:3], active_kind[12:11],
  // height_setpoint_mm[28:13], phase_elapsed_ms[60:29], zeros above
  output logic [63:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_wdata
);

  logic [10:0] climb_speed;
  logic [11:0] tol;
  logic [11:0] td_level;
  logic [19:0] td_confirm;
  logic [19:0] extra_wait;
  logic [19:0] abort_land;
  logic [15:0] range_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      climb_speed <= 11'd150;
      tol <= 12'd30;
      td_level <= 12'd80;
      td_confirm <= 20'd300;
      extra_wait <= 20'd5000;
      abort_land <= 20'd2000;
      range_max <= 16'd4000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLIMB: climb_speed <= cfg_wdata[10:0];
        REG_TOL: tol <= cfg_wdata[11:0];
        REG_TD_LEVEL: td_level <= cfg_wdata[11:0];
        REG_TD_CONFIRM: td_confirm <= cfg_wdata;
        REG_EXTRA: extra_wait <= cfg_wdata;
        REG_ABORT_LAND: abort_land <= cfg_wdata;
        REG_RANGE_MAX: range_max <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input word
  logic [2:0] op;
  logic [31:0] now;
  logic [15:0] range;
  step_t in_step;
  logic stopped;

  // table
  step_t table_mem [MaxSteps];
  step_t rd_entry;
  logic [IdxW-1:0] rd_addr;

  // sequencer state
  logic [CntW-1:0] step_total;
  logic [1:0] run_phase;
  logic [7:0] current_step;
  logic [1:0] current_kind;
  logic [15:0] height_setpoint;
  logic [15:0] ramp_origin;
  logic [10:0] ramp_goal;
  logic [31:0] phase_start;
  logic [19:0] active_hold;
  logic [19:0] active_limit;
  logic [31:0] qualify_start;
  logic qualifying;
  logic rej;
  logic [1:0] exec_kind;
  logic enter_pend;

  state_t state, state_next;
  div_req_t dreq;
  div_rsp_t drsp;

  sgas_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);

  // table write for an accepted add, in EXEC once add_ok has validated it
  logic add_ok;
  always_comb begin
    add_ok = 1'b0;
    if (run_phase == PH_IDLE && step_total < CntW'(MaxSteps)) begin
      case (in_step.kind)
        KIND_TAKEOFF: add_ok = in_step.height != 11'd0 && in_step.height <= HEIGHT_MAX_MM &&
                               in_step.timeout_ms > in_step.time_ms;
        KIND_DELAY: add_ok = in_step.time_ms != 20'd0;
        KIND_LAND: add_ok = in_step.height <= HEIGHT_MAX_MM && in_step.time_ms != 20'd0;
        default: add_ok = 1'b0;
      endcase
    end
  end

  // next step index
  logic [7:0] nxt_idx;
  logic nxt_ok;
  assign nxt_idx = current_step + 8'd1;
  assign nxt_ok = ({1'b0, nxt_idx} < {{(9 - CntW){1'b0}}, step_total}) &&
                  (nxt_idx < 8'(MaxSteps));
  logic cur_ok;
  assign cur_ok = ({1'b0, current_step} < {{(9 - CntW){1'b0}}, step_total}) &&
                  (current_step < 8'(MaxSteps));

  // start reads the last stored step; everything else reads the current step
  always_comb begin
    rd_addr = current_step[IdxW-1:0];
    if (state == ST_READ && op == OP_START) rd_addr = IdxW'(step_total - CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && op == OP_ADD && add_ok)
      table_mem[step_total[IdxW-1:0]] <= in_step;
    rd_entry <= table_mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: state_next = ST_DIV;
      ST_DIV: if (!dreq.start && !drsp.busy) state_next = ST_FIN;
      ST_FIN: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ENTER;
      ST_ENTER: state_next = ST_OUT;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op <= s_tdata[2:0];
      now <= s_tdata[34:3];
      range <= s_tdata[50:35];
      in_step.kind <= s_tdata[52:51];
      in_step.height <= s_tdata[63:53];
      in_step.time_ms <= s_tdata[83:64];
      in_step.timeout_ms <= s_tdata[103:84];
      stopped <= s_tdata[104];
    end
  end

  // ramp arithmetic
  logic [31:0] elapsed;
  assign elapsed = now - phase_start;
  logic [16:0] land_mag;
  logic land_down;
  assign land_down = {5'd0, ramp_goal} < ramp_origin;
  assign land_mag = land_down ? {1'b0, ramp_origin} - {6'd0, ramp_goal}
                              : {6'd0, ramp_goal} - {1'b0, ramp_origin};
  logic [42:0] climb_prod;
  assign climb_prod = elapsed * climb_speed;
  // landing divides only while elapsed < hold, so elapsed fits in 20 bits
  logic [36:0] land_mul;
  assign land_mul = elapsed[19:0] * land_mag;
  logic [47:0] land_prod;
  assign land_prod = {11'd0, land_mul};

  logic div_land;
  logic use_div;
  logic [47:0] q;
  assign q = drsp.quotient;

  logic [15:0] sp_calc;
  always_comb begin
    sp_calc = height_setpoint;
    if (div_land) begin
      if (land_down) sp_calc = ramp_origin - q[15:0];
      else sp_calc = ramp_origin + q[15:0];
    end else if ({5'd0, ramp_goal} >= ramp_origin) begin
      if ({32'd0, ramp_origin} + q > {37'd0, ramp_goal}) sp_calc = {5'd0, ramp_goal};
      else sp_calc = ramp_origin + q[15:0];
    end else begin
      if (q > {31'd0, land_mag}) sp_calc = {5'd0, ramp_goal};
      else sp_calc = ramp_origin - q[15:0];
    end
  end

  logic [16:0] tdiff;
  assign tdiff = ({1'b0, range} >= {6'd0, ramp_goal}) ? {1'b0, range} - {6'd0, ramp_goal}
                                                     : {6'd0, ramp_goal} - {1'b0, range};
  logic rvalid;
  assign rvalid = range <= range_max;

  always_comb begin
    use_div = 1'b0;
    div_land = 1'b0;
    if (op == OP_TICK) begin
      if (run_phase == PH_RUN && cur_ok && rd_entry.kind == KIND_TAKEOFF) use_div = 1'b1;
      if (run_phase == PH_LAND && active_hold != 20'd0 && elapsed < {12'd0, active_hold}) begin
        use_div = 1'b1;
        div_land = 1'b1;
      end
    end
  end

  always_comb begin
    dreq.start = 1'b0;
    dreq.dividend = {5'd0, climb_prod};
    dreq.divisor = 20'd1000;
    if (state == ST_EXEC && use_div) begin
      dreq.start = 1'b1;
      if (div_land) begin
        dreq.dividend = land_prod;
        dreq.divisor = active_hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_total <= '0;
      run_phase <= PH_IDLE;
      current_step <= IDX_IDLE;
      current_kind <= ACT_NONE;
      height_setpoint <= '0;
      ramp_origin <= '0;
      ramp_goal <= '0;
      phase_start <= '0;
      active_hold <= '0;
      active_limit <= '0;
      qualify_start <= '0;
      qualifying <= 1'b0;
      rej <= 1'b0;
      exec_kind <= KIND_TAKEOFF;
      enter_pend <= 1'b0;
    end else begin
      case (state)
        ST_READ: begin
          rej <= 1'b0;
        end
        ST_EXEC: begin
          exec_kind <= rd_entry.kind;
          case (op)
            OP_TICK: ;
            OP_CLEAR: begin
              if (run_phase != PH_IDLE) rej <= 1'b1;
              else step_total <= '0;
            end
            OP_ADD: begin
              if (add_ok) step_total <= step_total + CntW'(1);
              else rej <= 1'b1;
            end
            OP_START: begin
              // rd_entry holds the last stored step here
              if (run_phase != PH_IDLE || !stopped || step_total == '0 ||
                  rd_entry.kind != KIND_LAND)
                rej <= 1'b1;
              else begin
                height_setpoint <= range;
                current_step <= 8'd0;
                enter_pend <= 1'b1;
              end
            end
            OP_CANCEL: begin
              if (run_phase == PH_IDLE) rej <= 1'b1;
              else if (run_phase == PH_RUN) begin
                ramp_goal <= '0;
                active_hold <= abort_land;
                ramp_origin <= height_setpoint;
                phase_start <= now;
                qualifying <= 1'b0;
                current_step <= IDX_ABORT;
                current_kind <= ACT_LAND;
                run_phase <= PH_LAND;
              end
            end
            OP_ABORT: begin
              run_phase <= PH_IDLE;
              current_step <= IDX_IDLE;
              step_total <= '0;
            end
            default: rej <= 1'b1;
          endcase
        end
        ST_FIN: begin
          if (op == OP_TICK && run_phase == PH_RUN && cur_ok && exec_kind == KIND_TAKEOFF) begin
            height_setpoint <= sp_calc;
            if (rvalid && {4'd0, tdiff} <= {9'd0, tol} &&
                (qualifying ? (now - qualify_start) >= {12'd0, active_hold}
                            : active_hold == 20'd0)) begin
              qualifying <= 1'b1;
              if (!qualifying) qualify_start <= now;
              current_step <= nxt_idx;
              if (nxt_ok) enter_pend <= 1'b1;
              else begin
                run_phase <= PH_IDLE;
                current_step <= IDX_IDLE;
                step_total <= '0;
              end
            end else begin
              if (rvalid && {4'd0, tdiff} <= {9'd0, tol}) begin
                qualifying <= 1'b1;
                if (!qualifying) qualify_start <= now;
              end else qualifying <= 1'b0;
              if (elapsed >= {12'd0, active_limit}) begin
                ramp_goal <= '0;
                active_hold <= abort_land;
                ramp_origin <= sp_calc;
                phase_start <= now;
                qualifying <= 1'b0;
                current_step <= IDX_ABORT;
                current_kind <= ACT_LAND;
                run_phase <= PH_LAND;
              end
            end
          end
          if (op == OP_TICK && run_phase == PH_RUN && cur_ok && exec_kind == KIND_DELAY) begin
            height_setpoint <= ramp_origin;
            if (elapsed >= {12'd0, active_hold}) begin
              current_step <= nxt_idx;
              if (nxt_ok) enter_pend <= 1'b1;
              else begin
                run_phase <= PH_IDLE;
                current_step <= IDX_IDLE;
                step_total <= '0;
              end
            end
          end
          if (op == OP_TICK && run_phase == PH_LAND) begin
            if (div_land) height_setpoint <= sp_calc;
            else height_setpoint <= {5'd0, ramp_goal};
            if (rvalid && range <= {4'd0, td_level}) begin
              qualifying <= 1'b1;
              if (!qualifying) qualify_start <= now;
              if ((qualifying ? now - qualify_start : 32'd0) >= {12'd0, td_confirm}) begin
                run_phase <= PH_IDLE;
                current_step <= IDX_IDLE;
                step_total <= '0;
              end
            end else qualifying <= 1'b0;
            if ({1'b0, elapsed} >= {13'd0, active_hold} + {13'd0, extra_wait}) begin
              run_phase <= PH_IDLE;
              current_step <= IDX_IDLE;
              step_total <= '0;
            end
          end
        end
        ST_ENTER: begin
          // rd_entry holds the step at current_step, read during LOAD
          if (enter_pend) begin
            enter_pend <= 1'b0;
            case (rd_entry.kind)
              KIND_TAKEOFF: begin
                ramp_goal <= rd_entry.height;
                active_hold <= rd_entry.time_ms;
                active_limit <= rd_entry.timeout_ms;
                ramp_origin <= height_setpoint;
                phase_start <= now;
                qualifying <= 1'b0;
                current_kind <= ACT_TAKEOFF;
                run_phase <= PH_RUN;
              end
              KIND_DELAY: begin
                ramp_origin <= height_setpoint;
                phase_start <= now;
                active_hold <= rd_entry.time_ms;
                current_kind <= ACT_DELAY;
                run_phase <= PH_RUN;
              end
              KIND_LAND: begin
                ramp_goal <= rd_entry.height;
                active_hold <= rd_entry.time_ms;
                ramp_origin <= height_setpoint;
                phase_start <= now;
                qualifying <= 1'b0;
                current_kind <= ACT_LAND;
                run_phase <= PH_LAND;
              end
              default: begin
                run_phase <= PH_IDLE;
                current_step <= IDX_IDLE;
                step_total <= '0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  logic [31:0] elapsed_out;
  assign elapsed_out = (run_phase == PH_IDLE) ? 32'd0 : now - phase_start;

  assign m_tdata = {3'd0, elapsed_out, height_setpoint, current_kind, current_step,
                    run_phase, rej};

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sgas_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd6;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;
  localparam int IdleLimit = 5000;
  localparam int ItemGoal = 1900;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] now_ms;
    logic [15:0] range_mm;
    logic [1:0]  kind;
    logic [10:0] height;
    logic [19:0] hold_ms;
    logic [19:0] limit_ms;
    logic        stopped;
  } cmd_t;

  typedef struct packed {
    logic        rejected;
    logic [1:0]  phase;
    logic [7:0]  step_index;
    logic [1:0]  active_kind;
    logic [15:0] setpoint;
    logic [31:0] elapsed;
  } status_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [19:0]  cfg_wdata = '0;

  sensor_gated_altitude_step_sequencer_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // sequencer shadow: config and state
  int unsigned climb_speed, tol_mm, td_level, td_confirm, extra_wait, abort_land, range_max;
  step_t       prog[MaxSteps];
  int unsigned n_steps, cur_idx, sp_mm, ramp_from, ramp_to, ph_start, hold_ms, limit_ms;
  int unsigned qual_start;
  logic [1:0]  run_ph, act_kind;
  bit          qual;

  function automatic void to_idle();
    run_ph = PH_IDLE;
    cur_idx = IDX_IDLE;
    n_steps = 0;
  endfunction

  function automatic void begin_landing(int unsigned now, int unsigned goal, int unsigned dur,
                                        logic [7:0] idx);
    ramp_to = goal & 'h7FF;
    hold_ms = dur & 'hFFFFF;
    ramp_from = sp_mm;
    ph_start = now;
    qual = 1'b0;
    cur_idx = idx;
    act_kind = ACT_LAND;
    run_ph = PH_LAND;
  endfunction

  function automatic void begin_step(int unsigned now, int unsigned idx);
    cur_idx = idx;
    case (prog[idx].kind)
      KIND_TAKEOFF: begin
        ramp_to = prog[idx].height;
        hold_ms = prog[idx].time_ms;
        limit_ms = prog[idx].timeout_ms;
        ramp_from = sp_mm;
        ph_start = now;
        qual = 1'b0;
        act_kind = ACT_TAKEOFF;
        run_ph = PH_RUN;
      end
      KIND_DELAY: begin
        ramp_from = sp_mm;
        ph_start = now;
        hold_ms = prog[idx].time_ms;
        act_kind = ACT_DELAY;
        run_ph = PH_RUN;
      end
      KIND_LAND: begin_landing(now, prog[idx].height, prog[idx].time_ms, idx[7:0]);
      default: to_idle();
    endcase
  endfunction

  function automatic void next_step(int unsigned now);
    int unsigned nx;
    nx = (cur_idx + 1) & 'hFF;
    if (nx >= n_steps || nx >= MaxSteps) to_idle();
    else begin_step(now, nx);
  endfunction

  function automatic status_t sequencer_status(cmd_t c);
    status_t r;
    bit rej, done;
    int unsigned now, rng, el;
    longint unsigned dl, z;
    longint signed d, zs;
    int signed diff;
    rej = 1'b0;
    done = 1'b0;
    now = c.now_ms;
    rng = c.range_mm;
    case (c.op)
      OP_TICK: begin
        el = now - ph_start;
        if (run_ph == PH_RUN) begin
          if (cur_idx < n_steps && cur_idx < MaxSteps) begin
            if (prog[cur_idx].kind == KIND_TAKEOFF) begin
              dl = (longint'(climb_speed) * longint'(el)) / 1000;
              if (ramp_to >= ramp_from) begin
                z = longint'(ramp_from) + dl;
                sp_mm = (z > ramp_to) ? ramp_to : z[31:0];
              end else begin
                sp_mm = (dl > ramp_from - ramp_to) ? ramp_to : ramp_from - dl[31:0];
              end
              sp_mm &= 'hFFFF;
              diff = int'(rng) - int'(ramp_to);
              if (diff < 0) diff = -diff;
              if (rng <= range_max && diff <= int'(tol_mm)) begin
                if (!qual) begin
                  qual = 1'b1;
                  qual_start = now;
                end
                if (now - qual_start >= hold_ms) begin
                  next_step(now);
                  done = 1'b1;
                end
              end else begin
                qual = 1'b0;
              end
              if (!done && el >= limit_ms) begin_landing(now, 0, abort_land, IDX_ABORT);
            end else if (prog[cur_idx].kind == KIND_DELAY) begin
              sp_mm = ramp_from;
              if (el >= hold_ms) next_step(now);
            end
          end
        end else if (run_ph == PH_LAND) begin
          if (hold_ms == 0 || el >= hold_ms) begin
            sp_mm = ramp_to;
          end else begin
            d = longint'(ramp_to) - longint'(ramp_from);
            zs = longint'(ramp_from) + (d * longint'(el)) / longint'(hold_ms);
            sp_mm = zs[15:0];
          end
          if (rng <= range_max && rng <= td_level) begin
            if (!qual) begin
              qual = 1'b1;
              qual_start = now;
            end
            if (now - qual_start >= td_confirm) begin
              to_idle();
              done = 1'b1;
            end
          end else begin
            qual = 1'b0;
          end
          if (!done && longint'(el) >= longint'(hold_ms) + longint'(extra_wait)) to_idle();
        end
      end
      OP_CLEAR: begin
        if (run_ph != PH_IDLE) rej = 1'b1;
        else n_steps = 0;
      end
      OP_ADD: begin
        if (run_ph != PH_IDLE || n_steps >= MaxSteps) rej = 1'b1;
        else if (c.kind == KIND_TAKEOFF)
          rej = c.height == 0 || c.height > HEIGHT_MAX_MM || !(c.limit_ms > c.hold_ms);
        else if (c.kind == KIND_DELAY) rej = c.hold_ms == 0;
        else if (c.kind == KIND_LAND) rej = c.height > HEIGHT_MAX_MM || c.hold_ms == 0;
        else rej = 1'b1;
        if (!rej) begin
          prog[n_steps] = '{kind: c.kind, height: c.height, time_ms: c.hold_ms,
                            timeout_ms: c.limit_ms};
          n_steps++;
        end
      end
      OP_START: begin
        if (run_ph != PH_IDLE || !c.stopped || n_steps == 0 ||
            prog[n_steps - 1].kind != KIND_LAND) begin
          rej = 1'b1;
        end else begin
          sp_mm = rng;
          begin_step(now, 0);
        end
      end
      OP_CANCEL: begin
        if (run_ph == PH_IDLE) rej = 1'b1;
        else if (run_ph == PH_RUN) begin_landing(now, 0, abort_land, IDX_ABORT);
      end
      OP_ABORT: to_idle();
      default: rej = 1'b1;
    endcase
    r.rejected = rej;
    r.phase = run_ph;
    r.step_index = cur_idx[7:0];
    r.active_kind = act_kind;
    r.setpoint = sp_mm[15:0];
    r.elapsed = (run_ph == PH_IDLE) ? 32'd0 : now - ph_start;
    return r;
  endfunction

  // pending words and their predicted status, then status awaited from the block
  logic [111:0] cmd_q[$];
  status_t      status_q[$];
  status_t      awaited_q[$];
  status_t      drive_status;
  int unsigned  sim_ms;
  int           n_issued = 0;
  int           errors = 0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           quiet = 0;
  int           nwait;
  bit           s_took = 1'b0;
  bit           m_took = 1'b0;

  function automatic int draw_wait();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic issue(cmd_t c);
    if (!(c.op == OP_TICK && run_ph == PH_IDLE)) n_issued++;
    status_q.push_back(sequencer_status(c));
    cmd_q.push_back({7'd0, c.stopped, c.limit_ms, c.hold_ms, c.height, c.kind, c.range_mm,
                     c.now_ms, c.op});
  endtask

  function automatic cmd_t make_cmd(logic [2:0] op, logic [15:0] rng = 0);
    cmd_t c;
    c = '0;
    c.op = op;
    c.now_ms = sim_ms;
    c.range_mm = rng;
    c.stopped = 1'b1;
    return c;
  endfunction

  function automatic cmd_t make_step(logic [1:0] kind, logic [10:0] h, logic [19:0] t,
                                     logic [19:0] to);
    cmd_t c;
    c = make_cmd(OP_ADD);
    c.kind = kind;
    c.height = h;
    c.hold_ms = t;
    c.limit_ms = to;
    return c;
  endfunction

  task automatic drain();
    while (cmd_q.size() != 0 || awaited_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[19:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CLIMB: climb_speed = val & 'h7FF;
      REG_TOL: tol_mm = val & 'hFFF;
      REG_TD_LEVEL: td_level = val & 'hFFF;
      REG_TD_CONFIRM: td_confirm = val & 'hFFFFF;
      REG_EXTRA: extra_wait = val & 'hFFFFF;
      REG_ABORT_LAND: abort_land = val & 'hFFFFF;
      REG_RANGE_MAX: range_max = val & 'hFFFF;
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned v0, v1, v2, v3, v4, v5, v6);
    write_reg(REG_CLIMB, v0);
    write_reg(REG_TOL, v1);
    write_reg(REG_TD_LEVEL, v2);
    write_reg(REG_TD_CONFIRM, v3);
    write_reg(REG_EXTRA, v4);
    write_reg(REG_ABORT_LAND, v5);
    write_reg(REG_RANGE_MAX, v6);
  endtask

  function automatic cmd_t random_step();
    cmd_t c;
    int unsigned t;
    t = $urandom_range(0, 300);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = make_step(KIND_TAKEOFF, $urandom_range(1, 2000), t,
                                t + $urandom_range(1, 3000));
      4, 5, 6: c = make_step(KIND_DELAY, $urandom, $urandom_range(1, 500), $urandom);
      7: c = make_step(KIND_LAND, $urandom_range(0, 2000), $urandom_range(1, 1500), $urandom);
      default: c = make_step($urandom, $urandom, $urandom, $urandom);
    endcase
    return c;
  endfunction

  // one uploaded program, started and ticked until it ends (at most 400 further commands), with some noise
  task automatic run_program();
    cmd_t c;
    int nst, lo;
    sim_ms = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000);
    if ($urandom_range(0, 3) == 0) issue(make_cmd(OP_CLEAR));
    nst = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(0, 4);
    repeat (nst) issue(random_step());
    if ($urandom_range(0, 9) != 0)
      issue(make_step(KIND_LAND, $urandom_range(0, 2000), $urandom_range(1, 1500), $urandom));
    c = make_cmd(OP_START, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300));
    c.stopped = $urandom_range(0, 7) != 0;
    issue(c);
    for (int k = 0; k < 400 && run_ph != PH_IDLE; k++) begin
      sim_ms += ($urandom_range(0, 199) == 0) ? $urandom : $urandom_range(0, 40);
      case ($urandom_range(0, 99))
        0, 1: issue(make_cmd(OP_CANCEL));
        2: issue(make_cmd(OP_ABORT));
        3: issue(random_step());
        4: issue(make_cmd(($urandom_range(0, 1) == 0) ? OP_CLEAR : OP_START, $urandom));
        5: issue(make_cmd(($urandom_range(0, 1) == 0) ? OP_UNUSED_LO : OP_UNUSED_HI));
        default: begin
          c = make_cmd(OP_TICK, $urandom);
          if ($urandom_range(0, 9) < 7) begin
            if (run_ph == PH_LAND) begin
              c.range_mm = $urandom_range(0, td_level);
            end else begin
              lo = int'(ramp_to) - int'(tol_mm) - 2;
              c.range_mm = (lo < 0 ? 0 : lo) + $urandom_range(0, 2 * tol_mm + 4);
            end
          end else if ($urandom_range(0, 1) == 0) begin
            c.range_mm = $urandom_range(0, 4000);
          end
          issue(c);
        end
      endcase
    end
  endtask

  task automatic random_phase(int n);
    int target;
    target = n_issued + n;
    while (n_issued < target) run_program();
    drain();
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        s_tdata <= cmd_q.pop_front();
        drive_status <= status_q.pop_front();
        s_tvalid <= 1'b1;
        gap_left <= draw_wait();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_took) begin
      nwait = draw_wait();
      stall_left <= nwait;
      m_tready <= nwait == 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= stall_left == 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    status_t got, want;
    s_took <= !rst && s_tvalid && s_tready;
    m_took <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) awaited_q.push_back(drive_status);
      if (m_tvalid && m_tready) begin
        got.rejected = m_tdata[0];
        got.phase = m_tdata[2:1];
        got.step_index = m_tdata[10:3];
        got.active_kind = m_tdata[12:11];
        got.setpoint = m_tdata[28:13];
        got.elapsed = m_tdata[60:29];
        if (awaited_q.size() == 0) begin
          $error("unexpected word %h", m_tdata);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (got.rejected !== want.rejected) begin
            $error("rejected: expected %0d got %0d", want.rejected, got.rejected);
            errors++;
          end
          if (got.phase !== want.phase) begin
            $error("phase: expected %0d got %0d", want.phase, got.phase);
            errors++;
          end
          if (got.step_index !== want.step_index) begin
            $error("step_index: expected %0d got %0d", want.step_index, got.step_index);
            errors++;
          end
          if (got.active_kind !== want.active_kind) begin
            $error("active_kind: expected %0d got %0d", want.active_kind, got.active_kind);
            errors++;
          end
          if (got.setpoint !== want.setpoint) begin
            $error("height_setpoint_mm: expected %0d got %0d", want.setpoint, got.setpoint);
            errors++;
          end
          if (got.elapsed !== want.elapsed) begin
            $error("phase_elapsed_ms: expected %0d got %0d", want.elapsed, got.elapsed);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IdleLimit) begin
        $display("sensor_gated_altitude_step_sequencer_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    cmd_t c;
    climb_speed = 150; tol_mm = 30; td_level = 80; td_confirm = 300;
    extra_wait = 5000; abort_land = 2000; range_max = 4000;
    n_steps = 0; run_ph = PH_IDLE; cur_idx = IDX_IDLE; act_kind = ACT_NONE;
    sp_mm = 0; ramp_from = 0; ramp_to = 0; ph_start = 0; hold_ms = 0; limit_ms = 0;
    qual_start = 0; qual = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: idle commands, step validation, full table, start rules
    sim_ms = 32'hFFFF_FF00;
    issue(make_cmd(OP_TICK, 16'hFFFF));
    issue(make_cmd(OP_CANCEL));
    issue(make_cmd(OP_UNUSED_LO));
    issue(make_cmd(OP_UNUSED_HI));
    issue(make_step(KIND_TAKEOFF, 0, 10, 20));
    issue(make_step(KIND_TAKEOFF, 2001, 10, 20));
    issue(make_step(KIND_TAKEOFF, 100, 20, 20));
    issue(make_step(KIND_DELAY, 5, 0, 0));
    issue(make_step(KIND_LAND, 2001, 10, 0));
    issue(make_step(KIND_LAND, 0, 0, 0));
    issue(make_step(2'd3, 11'h7FF, 20'hFFFFF, 20'hFFFFF));
    issue(make_step(KIND_DELAY, 11'h7FF, 20'hFFFFF, 20'hFFFFF));
    issue(make_cmd(OP_START));
    for (int k = 1; k < MaxSteps; k++) issue(make_step(KIND_DELAY, 0, 1, 0));
    issue(make_step(KIND_LAND, 0, 1, 0));
    issue(make_cmd(OP_START));
    issue(make_cmd(OP_CLEAR));
    issue(make_step(KIND_TAKEOFF, 2000, 0, 20'hFFFFF));
    issue(make_step(KIND_LAND, 2000, 20'hFFFFF, 0));
    c = make_cmd(OP_START, 16'hFFFF);
    c.stopped = 1'b0;
    issue(c);
    issue(make_cmd(OP_START, 16'd50));
    issue(make_cmd(OP_CLEAR));
    sim_ms += 300;
    issue(make_cmd(OP_TICK, 16'd2000));
    issue(make_cmd(OP_CANCEL));
    issue(make_cmd(OP_CANCEL));
    issue(make_cmd(OP_ABORT));
    drain();

    random_phase(450);
    write_all(2000, 4000, 4000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 65535);
    random_phase(350);
    write_all(0, 0, 0, 0, 0, 1, 0);
    random_phase(350);
    write_all($urandom_range(50, 1000), $urandom_range(5, 200), $urandom_range(20, 300),
              $urandom_range(0, 500), $urandom_range(0, 3000), $urandom_range(1, 3000),
              $urandom_range(500, 8000));
    random_phase(ItemGoal - n_issued);
    write_all(150, 30, 80, 300, 5000, 2000, 4000);
    random_phase(100);

    if (errors == 0) begin
      $display("sensor_gated_altitude_step_sequencer_top regression: pass");
    end else begin
      $display("sensor_gated_altitude_step_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule
